@@ design/hsc_pkg.sv @@
package hsc_pkg;

    // Number of rotor sectors in one electrical turn
    localparam int unsigned SECTORS = 6;
    localparam int unsigned LAST_SECTOR = 5;

    // Field widths
    localparam int unsigned HALL_W  = 3;
    localparam int unsigned POS_W   = 3;
    localparam int unsigned MASK_W  = 6;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned DUTY_W  = 16;
    localparam int unsigned TABLE_W = SECTORS * MASK_W;

    // Stream data widths, rounded up to whole bytes
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 48;
    localparam int unsigned OUT_USED_W = 2 * (POS_W + MASK_W + 2 * PHASE_W) + DUTY_W;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = TABLE_W;

    localparam logic [TABLE_W-1:0] TABLE_RESET = 36'd26073516105;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TABLE     = 2'd0,
        REG_DIRECTION = 2'd1,
        REG_PWM_MODE  = 2'd2,
        REG_DUTY      = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PWM_HIGH  = 2'd0,
        PWM_LOW   = 2'd1,
        PWM_FRONT = 2'd2,
        PWM_BACK  = 2'd3
    } pwm_mode_t;

    // Drive pattern for one sector
    typedef struct packed {
        logic [MASK_W-1:0]  enable;
        logic [PHASE_W-1:0] chopped;
        logic [PHASE_W-1:0] forced;
    } sector_drive_t;

    // Hall code to sector: C=0, A+C=1, A=2, A+B=3, B=4, B+C=5; 000 and 111 map to 0
    function automatic logic [POS_W-1:0] hall_decode(input logic [HALL_W-1:0] code);
        logic [POS_W-1:0] pos;
        begin
            case (code)
                3'd1:    pos = 3'd2;
                3'd2:    pos = 3'd4;
                3'd3:    pos = 3'd3;
                3'd5:    pos = 3'd1;
                3'd6:    pos = 3'd5;
                default: pos = 3'd0;
            endcase
            return pos;
        end
    endfunction

    // Following sector in the chosen direction
    function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] pos,
                                                 input logic negative);
        logic [POS_W-1:0] nxt;
        begin
            if (negative)
            begin
                nxt = (pos == POS_W'(0)) ? POS_W'(LAST_SECTOR) : pos - POS_W'(1);
            end
            else
            begin
                nxt = (pos == POS_W'(LAST_SECTOR)) ? POS_W'(0) : pos + POS_W'(1);
            end
            return nxt;
        end
    endfunction

endpackage

@@ design/hsc_sector.sv @@
module hsc_sector
(
    input  logic [hsc_pkg::TABLE_W-1:0] table_bits,
    input  logic                        direction,
    input  hsc_pkg::pwm_mode_t          pwm_mode,
    input  logic [hsc_pkg::POS_W-1:0]   pos,
    output hsc_pkg::sector_drive_t      drive
);

    logic [hsc_pkg::MASK_W-1:0]  entry;
    logic [hsc_pkg::MASK_W-1:0]  entry_follow;
    logic [hsc_pkg::MASK_W-1:0]  both;
    logic [hsc_pkg::MASK_W-1:0]  rest;
    logic [hsc_pkg::PHASE_W-1:0] hi;
    logic [hsc_pkg::PHASE_W-1:0] lo;
    logic [hsc_pkg::PHASE_W-1:0] front;
    logic [hsc_pkg::PHASE_W-1:0] back;
    logic [hsc_pkg::PHASE_W-1:0] set_a;
    logic [hsc_pkg::PHASE_W-1:0] set_b;

    function automatic logic [hsc_pkg::MASK_W-1:0] pick_entry(
        input logic [hsc_pkg::TABLE_W-1:0] tbl,
        input logic [hsc_pkg::POS_W-1:0]   idx
    );
        logic [hsc_pkg::MASK_W-1:0] e;
        begin
            unique case (idx)
                3'd0:    e = tbl[5:0];
                3'd1:    e = tbl[11:6];
                3'd2:    e = tbl[17:12];
                3'd3:    e = tbl[23:18];
                3'd4:    e = tbl[29:24];
                3'd5:    e = tbl[35:30];
                default: e = '0;
            endcase
            return e;
        end
    endfunction

    // Table entries for this sector and the one after it in positive order
    always_comb
    begin
        entry        = pick_entry(table_bits, pos);
        entry_follow = pick_entry(table_bits, hsc_pkg::advance(pos, 1'b0));
    end

    // Phase sets: high side, low side, front and back sixty degrees
    always_comb
    begin
        both  = entry & entry_follow;
        rest  = entry ^ both;
        hi    = {entry[4], entry[2], entry[0]};
        lo    = {entry[5], entry[3], entry[1]};
        front = {both[5] | both[4], both[3] | both[2], both[1] | both[0]};
        back  = {rest[5] | rest[4], rest[3] | rest[2], rest[1] | rest[0]};
    end

    // Mode selects which set is chopped
    always_comb
    begin
        unique case (pwm_mode)
            hsc_pkg::PWM_HIGH:
            begin
                set_a = hi;
                set_b = lo;
            end
            hsc_pkg::PWM_LOW:
            begin
                set_a = lo;
                set_b = hi;
            end
            hsc_pkg::PWM_FRONT:
            begin
                set_a = front;
                set_b = back;
            end
            default:
            begin
                set_a = back;
                set_b = front;
            end
        endcase
    end

    // Negative direction swaps high/low switches and the two sets
    always_comb
    begin
        if (direction)
        begin
            drive.enable  = {entry[4], entry[5], entry[2], entry[3], entry[0], entry[1]};
            drive.chopped = set_b;
            drive.forced  = set_a;
        end
        else
        begin
            drive.enable  = entry;
            drive.chopped = set_a;
            drive.forced  = set_b;
        end
    end

endmodule

@@ design/hall_six_step_commutator.sv @@
// Channel   Direction  Payload
// s_axis    in         tdata[2:0] hall_code
// m_axis    out        tdata: sector pattern for now and next, compare value; tuser: hall_invalid
// cfg       in         cfg_index register number, cfg_data value (low bits used)
//
// One item per cycle sustained while m_axis is not stalled; input register, then result register.
// The decode and both table lookups sit between those two registers.
// Reset loads the commutation table default, positive direction, high-side PWM, duty 0.
// A stall on m_axis backs up through the result register; the input register
// still takes an item whenever the result register is empty or being drained.
// cfg_ready is always high.
module hall_six_step_commutator
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [hsc_pkg::IN_DATA_W-1:0]        s_axis_tdata,  // [2:0] hall_code

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [2:0] position, [8:3] now_enable, [11:9] now_chopped, [14:12] now_forced,
    // [17:15] next_position, [23:18] next_enable, [26:24] next_chopped,
    // [29:27] next_forced, [45:30] compare_value
    output logic [hsc_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                 m_axis_tuser,  // [0] hall_invalid

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hsc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [hsc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic [hsc_pkg::TABLE_W-1:0]     table_reg;
    logic                            direction_reg;
    hsc_pkg::pwm_mode_t              pwm_mode_reg;
    logic [hsc_pkg::DUTY_W-1:0]      duty_reg;

    logic                            in_valid_reg;
    logic [hsc_pkg::HALL_W-1:0]      code_reg;
    logic                            out_valid_reg;
    logic [hsc_pkg::OUT_DATA_W-1:0]  out_data_reg;
    logic                            out_user_reg;

    logic                            out_load;
    logic                            in_load;
    logic [hsc_pkg::POS_W-1:0]       pos;
    logic [hsc_pkg::POS_W-1:0]       follow_pos;
    logic                            invalid;
    logic [hsc_pkg::DUTY_W-1:0]      compare;
    hsc_pkg::sector_drive_t          now_drive;
    hsc_pkg::sector_drive_t          next_drive;
    logic [hsc_pkg::OUT_DATA_W-1:0]  out_data_next;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_reg     <= hsc_pkg::TABLE_RESET;
            direction_reg <= 1'b0;
            pwm_mode_reg  <= hsc_pkg::PWM_HIGH;
            duty_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (hsc_pkg::cfg_index_t'(cfg_index))
                hsc_pkg::REG_TABLE:     table_reg     <= cfg_data[hsc_pkg::TABLE_W-1:0];
                hsc_pkg::REG_DIRECTION: direction_reg <= cfg_data[0];
                hsc_pkg::REG_PWM_MODE:  pwm_mode_reg  <= hsc_pkg::pwm_mode_t'(cfg_data[1:0]);
                hsc_pkg::REG_DUTY:      duty_reg      <= cfg_data[hsc_pkg::DUTY_W-1:0];
                default:                duty_reg      <= duty_reg;
            endcase
        end
    end

    // Pipeline flow control
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign in_load       = !in_valid_reg || out_load;
    assign s_axis_tready = in_load;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && s_axis_tvalid)
        begin
            code_reg <= s_axis_tdata[hsc_pkg::HALL_W-1:0];
        end
    end

    // Sector decode and compare value
    always_comb
    begin
        pos        = hsc_pkg::hall_decode(code_reg);
        follow_pos = hsc_pkg::advance(pos, direction_reg);
        invalid    = (code_reg == 3'b000) || (code_reg == 3'b111);
        compare    = (duty_reg == '0) ? hsc_pkg::DUTY_W'(1) : duty_reg;
    end

    hsc_sector u_now
    (
        .table_bits (table_reg),
        .direction  (direction_reg),
        .pwm_mode   (pwm_mode_reg),
        .pos        (pos),
        .drive      (now_drive)
    );

    hsc_sector u_next
    (
        .table_bits (table_reg),
        .direction  (direction_reg),
        .pwm_mode   (pwm_mode_reg),
        .pos        (follow_pos),
        .drive      (next_drive)
    );

    // Pack the result item
    assign out_data_next = {
        (hsc_pkg::OUT_DATA_W - hsc_pkg::OUT_USED_W)'(0),
        compare,
        next_drive.forced,
        next_drive.chopped,
        next_drive.enable,
        follow_pos,
        now_drive.forced,
        now_drive.chopped,
        now_drive.enable,
        pos
    };

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= invalid;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

@@ design/hsc_checker.sv @@
module hsc_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [hsc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic                            m_axis_tuser
);

    // A stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    // With the output side empty the pipeline must take an item
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // Compare value never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[45:30] != 16'd0))
        else $error("compare value is zero");

    // Both sector indexes in range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= 3'd5) && (m_axis_tdata[17:15] <= 3'd5))
        else $error("sector index out of range");

    // Invalid Hall code falls back to sector 0
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[2:0] == 3'd0))
        else $error("invalid code not mapped to sector 0");

endmodule

bind hall_six_step_commutator hsc_checker u_hsc_checker (.*);

@@ tb/hall_commutation_checker.sv @@
`timescale 1ns / 1ps

// Watches the hall input, result and register channels of the commutator,
// predicts every result from its own copy of the registers and compares.
module hall_commutation_checker
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [hsc_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [2:0] hall_code

    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [2:0] position, [8:3] now_enable, [11:9] now_chopped, [14:12] now_forced,
    // [17:15] next_position, [23:18] next_enable, [26:24] next_chopped,
    // [29:27] next_forced, [45:30] compare_value
    input  logic [hsc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                            m_axis_tuser,   // [0] hall_invalid

    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [hsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hsc_pkg::CFG_DATA_W-1:0]  cfg_data,

    output int                              fail_count,
    output int                              pending,
    output int                              results_checked
);

    // Full drive picture for one hall code
    typedef struct packed {
        logic [hsc_pkg::POS_W-1:0]  position;
        logic                       invalid;
        hsc_pkg::sector_drive_t     now;
        logic [hsc_pkg::POS_W-1:0]  upcoming_position;
        hsc_pkg::sector_drive_t     upcoming;
        logic [hsc_pkg::DUTY_W-1:0] compare;
    } commutation_t;

    // Shadow registers
    logic [hsc_pkg::TABLE_W-1:0] shadow_table;
    logic                        shadow_negative;
    hsc_pkg::pwm_mode_t          shadow_mode;
    logic [hsc_pkg::DUTY_W-1:0]  shadow_duty;

    commutation_t drives_due[$];

    initial
    begin
        fail_count      = 0;
        pending         = 0;
        results_checked = 0;
    end

    // One bit per phase: any switch of that phase set
    function automatic logic [hsc_pkg::PHASE_W-1:0] phases_touched(
        input logic [hsc_pkg::MASK_W-1:0] m);
        return {m[5] | m[4], m[3] | m[2], m[1] | m[0]};
    endfunction

    // Enables, chopped and forced phases for one sector
    function automatic hsc_pkg::sector_drive_t sector_drive(
        input logic [hsc_pkg::POS_W-1:0] sector);
        logic [hsc_pkg::MASK_W-1:0]  cur;
        logic [hsc_pkg::MASK_W-1:0]  follow;
        logic [hsc_pkg::MASK_W-1:0]  shared;
        logic [hsc_pkg::PHASE_W-1:0] hi;
        logic [hsc_pkg::PHASE_W-1:0] lo;
        logic [hsc_pkg::PHASE_W-1:0] front;
        logic [hsc_pkg::PHASE_W-1:0] back;
        logic [hsc_pkg::PHASE_W-1:0] first;
        logic [hsc_pkg::PHASE_W-1:0] second;
        int                          s;
        hsc_pkg::sector_drive_t      d;
        s      = int'(sector);
        cur    = shadow_table[hsc_pkg::MASK_W*s +: hsc_pkg::MASK_W];
        follow = shadow_table[hsc_pkg::MASK_W*((s + 1) % hsc_pkg::SECTORS) +: hsc_pkg::MASK_W];
        shared = cur & follow;
        hi     = {cur[4], cur[2], cur[0]};
        lo     = {cur[5], cur[3], cur[1]};
        front  = phases_touched(shared);
        back   = phases_touched(cur ^ shared);
        case (shadow_mode)
            hsc_pkg::PWM_HIGH:  begin first = hi;    second = lo;    end
            hsc_pkg::PWM_LOW:   begin first = lo;    second = hi;    end
            hsc_pkg::PWM_FRONT: begin first = front; second = back;  end
            default:            begin first = back;  second = front; end
        endcase
        // negative rotation swaps high and low switch of every phase
        if (shadow_negative)
        begin
            d.enable  = {cur[4], cur[5], cur[2], cur[3], cur[0], cur[1]};
            d.chopped = second;
            d.forced  = first;
        end
        else
        begin
            d.enable  = cur;
            d.chopped = first;
            d.forced  = second;
        end
        return d;
    endfunction

    // Expected result for one hall code under the current registers
    function automatic commutation_t commutation_for(input logic [hsc_pkg::HALL_W-1:0] code);
        commutation_t r;
        case (code)
            3'd4:    r.position = 3'd0;
            3'd5:    r.position = 3'd1;
            3'd1:    r.position = 3'd2;
            3'd3:    r.position = 3'd3;
            3'd2:    r.position = 3'd4;
            3'd6:    r.position = 3'd5;
            default: r.position = 3'd0;
        endcase
        r.invalid = (code == 3'd0) || (code == 3'd7);
        if (shadow_negative)
            r.upcoming_position = (r.position == 3'd0)
                                ? hsc_pkg::POS_W'(hsc_pkg::LAST_SECTOR)
                                : r.position - 3'd1;
        else
            r.upcoming_position = (r.position == hsc_pkg::POS_W'(hsc_pkg::LAST_SECTOR))
                                ? 3'd0
                                : r.position + 3'd1;
        r.now      = sector_drive(r.position);
        r.upcoming = sector_drive(r.upcoming_position);
        r.compare  = (shadow_duty == '0) ? hsc_pkg::DUTY_W'(1) : shadow_duty;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [hsc_pkg::DUTY_W-1:0] want,
                               input logic [hsc_pkg::DUTY_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        commutation_t want;
        if (!rst_n)
        begin
            shadow_table    = hsc_pkg::TABLE_RESET;
            shadow_negative = 1'b0;
            shadow_mode     = hsc_pkg::PWM_HIGH;
            shadow_duty     = '0;
            drives_due.delete();
            pending         = 0;
        end
        else
        begin
            // item in: predict with the registers in force
            if (s_axis_tvalid && s_axis_tready)
                drives_due.push_back(commutation_for(s_axis_tdata[hsc_pkg::HALL_W-1:0]));

            // result out: compare with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (drives_due.size() == 0)
                begin
                    $display("%0t: result with nothing pending, tdata %h tuser %b",
                             $time, m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end
                else
                begin
                    want = drives_due.pop_front();
                    check_field("position",
                                hsc_pkg::DUTY_W'(want.position),
                                hsc_pkg::DUTY_W'(m_axis_tdata[2:0]));
                    check_field("hall_invalid",
                                hsc_pkg::DUTY_W'(want.invalid),
                                hsc_pkg::DUTY_W'(m_axis_tuser));
                    check_field("now_enable",
                                hsc_pkg::DUTY_W'(want.now.enable),
                                hsc_pkg::DUTY_W'(m_axis_tdata[8:3]));
                    check_field("now_chopped",
                                hsc_pkg::DUTY_W'(want.now.chopped),
                                hsc_pkg::DUTY_W'(m_axis_tdata[11:9]));
                    check_field("now_forced",
                                hsc_pkg::DUTY_W'(want.now.forced),
                                hsc_pkg::DUTY_W'(m_axis_tdata[14:12]));
                    check_field("next_position",
                                hsc_pkg::DUTY_W'(want.upcoming_position),
                                hsc_pkg::DUTY_W'(m_axis_tdata[17:15]));
                    check_field("next_enable",
                                hsc_pkg::DUTY_W'(want.upcoming.enable),
                                hsc_pkg::DUTY_W'(m_axis_tdata[23:18]));
                    check_field("next_chopped",
                                hsc_pkg::DUTY_W'(want.upcoming.chopped),
                                hsc_pkg::DUTY_W'(m_axis_tdata[26:24]));
                    check_field("next_forced",
                                hsc_pkg::DUTY_W'(want.upcoming.forced),
                                hsc_pkg::DUTY_W'(m_axis_tdata[29:27]));
                    check_field("compare_value", want.compare, m_axis_tdata[45:30]);
                    results_checked++;
                end
            end

            // register write, masked to the register width
            if (cfg_valid && cfg_ready)
            begin
                case (hsc_pkg::cfg_index_t'(cfg_index))
                    hsc_pkg::REG_TABLE:     shadow_table    = cfg_data[hsc_pkg::TABLE_W-1:0];
                    hsc_pkg::REG_DIRECTION: shadow_negative = cfg_data[0];
                    hsc_pkg::REG_PWM_MODE:  shadow_mode     = hsc_pkg::pwm_mode_t'(cfg_data[1:0]);
                    hsc_pkg::REG_DUTY:      shadow_duty     = cfg_data[hsc_pkg::DUTY_W-1:0];
                    default:                ;
                endcase
            end
            pending = drives_due.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 400;

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [hsc_pkg::IN_DATA_W-1:0]   s_axis_tdata;    // [2:0] hall_code
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [hsc_pkg::OUT_DATA_W-1:0]  m_axis_tdata;    // see checker for field layout
    logic                            m_axis_tuser;    // [0] hall_invalid
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [hsc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [hsc_pkg::CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int pending;
    int results_checked;
    int items_sent;
    int invalid_sent;
    int settings_applied;

    // shared with the receiver process
    logic quiet;
    logic long_hold;

    hall_six_step_commutator dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    hall_commutation_checker checker_i
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic [hsc_pkg::CFG_DATA_W-1:0] noisy_word();
        return {4'($urandom), 32'($urandom)};
    endfunction

    // Offer one hall code and wait until it is taken
    task automatic send_hall(input logic [hsc_pkg::HALL_W-1:0] code);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= hsc_pkg::IN_DATA_W'(code);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (code == 3'd0 || code == 3'd7)
            invalid_sent++;
        gap = quiet ? 0 : idle_cycles();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
    endtask

    // Wait until every offered item has come back, then a short settle
    task automatic wait_drained();
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic cfg_put(input hsc_pkg::cfg_index_t idx,
                           input logic [hsc_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Write all four registers; narrow ones get junk in the unused bits
    task automatic apply_settings(input logic [hsc_pkg::TABLE_W-1:0] tbl, input logic neg,
                                  input hsc_pkg::pwm_mode_t mode,
                                  input logic [hsc_pkg::DUTY_W-1:0] dv);
        logic [hsc_pkg::CFG_DATA_W-1:0] w;
        cfg_put(hsc_pkg::REG_TABLE, tbl);
        w = noisy_word();
        w[0] = neg;
        cfg_put(hsc_pkg::REG_DIRECTION, w);
        w = noisy_word();
        w[1:0] = mode;
        cfg_put(hsc_pkg::REG_PWM_MODE, w);
        w = noisy_word();
        w[hsc_pkg::DUTY_W-1:0] = dv;
        cfg_put(hsc_pkg::REG_DUTY, w);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // Result receiver with random stalls and one requested long hold-off
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (1 + idle_cycles()) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Watchdog: too long with no item moving on any channel
    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Watchdog: no activity for %0d cycles at %0t", WATCHDOG_LIMIT, $time);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        logic [hsc_pkg::HALL_W-1:0]  code;
        logic [hsc_pkg::TABLE_W-1:0] tbl;
        logic                        neg;
        hsc_pkg::pwm_mode_t          mode;
        logic [hsc_pkg::DUTY_W-1:0]  dv;
        logic [hsc_pkg::HALL_W-1:0]  hall_of_sector [hsc_pkg::SECTORS];
        int                          rot;
        int                          phase;
        int                          phase_len;
        int                          random_start;

        hall_of_sector = '{3'd4, 3'd5, 3'd1, 3'd3, 3'd2, 3'd6};
        clk              = 1'b0;
        rst_n            = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        m_axis_tready    = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = hsc_pkg::REG_TABLE;
        cfg_data         = '0;
        quiet            = 1'b0;
        long_hold        = 1'b0;
        items_sent       = 0;
        invalid_sent     = 0;
        settings_applied = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: every hall code, valid and invalid
        for (int c = 0; c < 8; c++)
            send_hall(hsc_pkg::HALL_W'(c));
        end_burst();
        wait_drained();

        // all switches set, negative rotation, back sixty, full duty
        apply_settings({hsc_pkg::TABLE_W{1'b1}}, 1'b1, hsc_pkg::PWM_BACK,
                       {hsc_pkg::DUTY_W{1'b1}});
        for (int s = 0; s < hsc_pkg::SECTORS; s++)
            send_hall(hall_of_sector[s]);
        end_burst();
        wait_drained();

        // empty table, front sixty, duty one, both invalid codes
        apply_settings('0, 1'b0, hsc_pkg::PWM_FRONT, hsc_pkg::DUTY_W'(1));
        send_hall(3'd0);
        send_hall(3'd7);
        send_hall(3'd1);
        end_burst();
        wait_drained();

        // random table, low-side PWM, negative, zero duty
        apply_settings(noisy_word(), 1'b1, hsc_pkg::PWM_LOW, '0);
        for (int s = hsc_pkg::SECTORS - 1; s >= 0; s--)
            send_hall(hall_of_sector[s]);
        end_burst();
        wait_drained();

        // random phases: mostly rotation sequences with occasional odd codes
        random_start = items_sent;
        phase = 0;
        rot = 0;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:       tbl = {hsc_pkg::TABLE_W{1'b1}};
                1:       tbl = '0;
                2:       tbl = hsc_pkg::TABLE_RESET;
                default: tbl = noisy_word();
            endcase
            case ($urandom_range(0, 5))
                0:       dv = '0;
                1:       dv = {hsc_pkg::DUTY_W{1'b1}};
                2:       dv = hsc_pkg::DUTY_W'(1);
                default: dv = hsc_pkg::DUTY_W'($urandom);
            endcase
            neg  = 1'($urandom_range(0, 1));
            mode = hsc_pkg::pwm_mode_t'($urandom_range(0, 3));
            apply_settings(tbl, neg, mode, dv);

            quiet = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(10, 40);
            // one phase backs up the output while items keep coming
            if (phase == 3)
            begin
                quiet     = 1'b1;
                long_hold = 1'b1;
                phase_len = 40;
            end
            rot = $urandom_range(0, hsc_pkg::SECTORS - 1);
            for (int k = 0; k < phase_len; k++)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    code = hall_of_sector[rot];
                    rot  = neg ? (rot + hsc_pkg::SECTORS - 1) % hsc_pkg::SECTORS
                               : (rot + 1) % hsc_pkg::SECTORS;
                end
                else
                    code = hsc_pkg::HALL_W'($urandom_range(0, 7));
                send_hall(code);
            end
            end_burst();
            wait_drained();
            quiet = 1'b0;
            phase++;
        end

        repeat (10) @(posedge clk);
        $display("Run covered %0d hall codes (%0d invalid) under %0d register settings,",
                 items_sent, invalid_sent, settings_applied);
        $display("with %0d results compared field by field and %0d mismatches.",
                 results_checked, fail_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
